/* design/positional_byte_list_top_defines.svh */
// ============================================================================
// positional_byte_list_top_defines
// Assertion macros used by the positional byte list design.
// ============================================================================
`ifndef POSITIONAL_BYTE_LIST_TOP_DEFINES_SVH
`define POSITIONAL_BYTE_LIST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PBL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/pbl_pkg.sv */
// ============================================================================
// pbl_pkg
// Types and constants for the positional byte list.
// ============================================================================
package pbl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 9) ? CNT_W : 9;
    localparam int DATA_W   = 8;
    localparam int POS_W    = 8;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND_TAIL = 3'd0,
        MODE_INSERT_POS  = 3'd1,
        MODE_PUSH_HEAD   = 3'd2,
        MODE_REMOVE_TAIL = 3'd3,
        MODE_REMOVE_HEAD = 3'd4,
        MODE_REMOVE_POS  = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [CNT_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } cell_op_t;

endpackage

/* design/positional_byte_list_top.sv */
// ============================================================================
// positional_byte_list_top
// Bounded ordered byte list built as a shift chain of cells.
// ============================================================================
// The result word of an accepted input word is registered and appears in the cycle after it.
// Throughput: one word per cycle while the output is not stalled; each cell picks hold, load or shift at once.
// The output register stalls the input only while a result waits and is stalled.
// Reset clears the element count and the output valid; cell contents and the result word are not cleared.
`include "positional_byte_list_top_defines.svh"

module positional_byte_list_top
    import pbl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [DATA_W-1:0] value,
    input  logic [POS_W-1:0]  position,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] removed_value,
    output logic [STAT_W-1:0] status,
    output logic [LEN_W-1:0]  length
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] removed_reg;
    logic [DATA_W-1:0] removed_next;
    status_t           status_reg;
    status_t           status_next;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;

    logic              accept;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  cnt_w;
    logic [CMP_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  idx;
    logic              do_ins;
    logic              do_rem;
    cell_op_t          op;
    logic [DATA_W-1:0] tap_or;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_tap  [CAPACITY];

    assign accept = in_valid && !in_stall;
    assign pos_w  = CMP_W'(position);
    assign cnt_w  = CMP_W'(count_reg);
    assign pos_m1 = pos_w - CMP_W'(1);

    always_comb
    begin
        idx         = count_reg;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        status_next = ST_OK;
        unique case (mode_t'(mode)) inside
            MODE_APPEND_TAIL, MODE_INSERT_POS, MODE_PUSH_HEAD:
            begin
                if (mode_t'(mode) == MODE_PUSH_HEAD)
                begin
                    idx = '0;
                end
                else if (mode_t'(mode) == MODE_INSERT_POS && pos_w != '0 && pos_m1 <= cnt_w)
                begin
                    idx = CNT_W'(pos_m1);
                end
                if (cnt_w == CMP_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            MODE_REMOVE_TAIL, MODE_REMOVE_HEAD, MODE_REMOVE_POS:
            begin
                if (mode_t'(mode) == MODE_REMOVE_TAIL)
                begin
                    idx = count_reg - CNT_W'(1);
                end
                else if (mode_t'(mode) == MODE_REMOVE_HEAD)
                begin
                    idx = '0;
                end
                else
                begin
                    idx = CNT_W'(pos_m1);
                end
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (mode_t'(mode) == MODE_REMOVE_POS && (pos_w == '0 || pos_m1 >= cnt_w))
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    do_rem = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign op.ins   = accept && do_ins;
    assign op.rem   = accept && do_rem;
    assign op.idx   = idx;
    assign op.value = value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            pbl_cell u_cell (
                .clk        (clk),
                .op         (op),
                .my_index   (CNT_W'(gi)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .tap        (cell_tap[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        removed_next   = do_rem ? tap_or : '0;
        length_next    = LEN_W'(count_next);
        out_valid_next = accept || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
            length_reg  <= length_next;
        end
    end

    assign in_stall      = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign length        = length_reg;

    `PBL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY), "count over capacity")
    `PBL_ASSERT_IMPL(a_full_len, clk, rst_n, out_valid_reg && status_reg == ST_FULL, length_reg == LEN_W'(CAPACITY), "full status with short list")
    `PBL_ASSERT_IMPL(a_empty_len, clk, rst_n, out_valid_reg && status_reg == ST_EMPTY, length_reg == '0, "empty status with entries")
    `PBL_ASSERT_NEXT(a_ins_grow, clk, rst_n, op.ins, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow list")

endmodule

/* design/pbl_cell.sv */
// ============================================================================
// pbl_cell
// One list slot: hold, load the new byte, or take a neighbor's byte.
// ============================================================================
module pbl_cell
    import pbl_pkg::*;
(
    input  logic              clk,
    input  cell_op_t          op,
    input  logic [CNT_W-1:0]  my_index,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] tap
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            if (my_index == op.idx)
            begin
                data_next = op.value;
            end
            else if (my_index > op.idx)
            begin
                data_next = left_data;
            end
        end
        else if (op.rem)
        begin
            if (my_index >= op.idx)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (my_index == op.idx) ? data_reg : '0;

endmodule

/* verif/positional_byte_list_top_tb.sv */
// ============================================================================
// positional_byte_list_top_tb
// Drives list operations through the byte list and checks every result word
// against an in-bench queue model of the list. Runs directed corner cases,
// a fill-to-capacity pass, a long output hold and random traffic under
// several idle and stall mixes.
// ============================================================================
module positional_byte_list_top_tb;
    import pbl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [DATA_W-1:0] removed_value;
        status_t           status;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] removed_value;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;

    logic [DATA_W-1:0] list_bytes[$];
    list_result_t      expected_results[$];
    int                error_count = 0;
    int                words_sent = 0;
    int                results_seen = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                hold_seq = 0;
    int                hold_seen = 0;
    int                hold_left = 0;

    positional_byte_list_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .status        (status),
        .length        (length)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic list_result_t apply_list_op(logic [MODE_W-1:0] m,
                                                   logic [DATA_W-1:0] v,
                                                   logic [POS_W-1:0] p);
        list_result_t r;
        int           n;
        int           idx;
        n = list_bytes.size();
        r.removed_value = '0;
        r.status = ST_OK;
        if (m == MODE_APPEND_TAIL || m == MODE_INSERT_POS || m == MODE_PUSH_HEAD)
        begin
            if (m == MODE_PUSH_HEAD)
                idx = 0;
            else if (m == MODE_APPEND_TAIL || p == 0)
                idx = n;
            else
                idx = int'(p) - 1;
            if (idx > n)
                idx = n;
            if (n >= CAPACITY)
                r.status = ST_FULL;
            else
                list_bytes.insert(idx, v);
        end
        else if (m == MODE_REMOVE_TAIL || m == MODE_REMOVE_HEAD
                 || m == MODE_REMOVE_POS)
        begin
            if (m == MODE_REMOVE_TAIL)
                idx = n - 1;
            else if (m == MODE_REMOVE_HEAD)
                idx = 0;
            else
                idx = int'(p) - 1;
            if (n == 0)
                r.status = ST_EMPTY;
            else if (idx < 0 || idx >= n)
                r.status = ST_NOT_FOUND;
            else
            begin
                r.removed_value = list_bytes[idx];
                list_bytes.delete(idx);
            end
        end
        r.length = LEN_W'(list_bytes.size());
        return r;
    endfunction

    always @(posedge clk)
    begin : check_and_predict
        list_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word: removed_value %0d status %0d length %0d",
                           removed_value, status, length);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (removed_value !== want.removed_value)
                    begin
                        $error("removed_value: expected %0d, got %0d",
                               want.removed_value, removed_value);
                        error_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (length !== want.length)
                    begin
                        $error("length: expected %0d, got %0d", want.length, length);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_list_op(mode, value, position));
        end
    end

    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                             input logic [POS_W-1:0] p);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct = 0;
        send_word(MODE_REMOVE_TAIL, 8'h11, 8'd0);
        send_word(MODE_REMOVE_HEAD, 8'h22, 8'd1);
        send_word(MODE_REMOVE_POS, 8'h33, 8'd1);
        send_word(MODE_REMOVE_POS, 8'h44, 8'd0);
        send_word(MODE_INSERT_POS, 8'hA5, 8'd0);
        send_word(MODE_REMOVE_POS, 8'h00, 8'd2);
        send_word(MODE_INSERT_POS, 8'h00, 8'd1);
        send_word(MODE_INSERT_POS, 8'hFF, 8'd255);
        send_word(MODE_INSERT_POS, 8'h5A, 8'd2);
        send_word(MODE_PUSH_HEAD, 8'h80, 8'd0);
        send_word(MODE_APPEND_TAIL, 8'h01, 8'd128);
        send_word(MODE_INSERT_POS, 8'h7F, 8'd7);
        send_word(MODE_REMOVE_POS, 8'h00, 8'd0);
        send_word(MODE_REMOVE_POS, 8'hFF, 8'd255);
        send_word(MODE_REMOVE_POS, 8'h00, 8'd3);
        send_word(MODE_REMOVE_TAIL, 8'h00, 8'd0);
        send_word(MODE_REMOVE_HEAD, 8'h00, 8'd0);
        send_word(MODE_SPARE_6, 8'hFF, 8'hFF);
        send_word(MODE_SPARE_7, 8'h00, 8'd1);
        send_word(MODE_REMOVE_POS, 8'h00, 8'd1);
        send_word(MODE_REMOVE_HEAD, 8'h00, 8'd0);
        send_word(MODE_REMOVE_TAIL, 8'h00, 8'd0);
        send_word(MODE_REMOVE_TAIL, 8'h00, 8'd0);
    endtask

    task automatic test_full_list();
        int i;
        for (i = 0; i < CAPACITY; i++)
            send_word((i % 2) ? MODE_PUSH_HEAD : MODE_APPEND_TAIL,
                      DATA_W'($urandom_range(255)), POS_W'($urandom_range(255)));
        send_word(MODE_APPEND_TAIL, 8'hC3, 8'd0);
        send_word(MODE_PUSH_HEAD, 8'h3C, 8'd0);
        send_word(MODE_INSERT_POS, 8'h96, 8'd1);
        send_word(MODE_INSERT_POS, 8'h69, 8'd0);
        send_word(MODE_INSERT_POS, 8'hE1, 8'd255);
        send_word(MODE_INSERT_POS, 8'h1E, 8'd9);
        send_word(MODE_REMOVE_POS, 8'h00, POS_W'(CAPACITY));
        send_word(MODE_REMOVE_POS, 8'h00, POS_W'(CAPACITY));
        send_word(MODE_INSERT_POS, 8'hB4, POS_W'(CAPACITY));
        send_word(MODE_REMOVE_POS, 8'h00, 8'd1);
        for (i = 0; i <= CAPACITY; i++)
            send_word(MODE_REMOVE_TAIL, DATA_W'($urandom_range(255)), 8'd0);
    endtask

    task automatic test_output_hold();
        int i;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_seq <= hold_seq + 1;
        for (i = 0; i < 30; i++)
            send_word(MODE_W'($urandom_range(5)), DATA_W'($urandom_range(255)),
                      POS_W'($urandom_range(17)));
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int hold_pct);
        int               i;
        int               pick;
        int               run_left;
        bit               grow;
        logic [MODE_W-1:0] m;
        logic [POS_W-1:0]  p;
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        grow = 1'b1;
        run_left = $urandom_range(8, 40);
        for (i = 0; i < count; i++)
        begin
            run_left--;
            if (run_left == 0)
            begin
                grow = !grow;
                run_left = $urandom_range(8, 40);
            end
            pick = $urandom_range(99);
            if (pick < 2)
                m = pick[0] ? MODE_SPARE_7 : MODE_SPARE_6;
            else if (pick < (grow ? 72 : 30))
                m = MODE_W'($urandom_range(MODE_PUSH_HEAD));
            else
                m = MODE_W'($urandom_range(MODE_REMOVE_POS, MODE_REMOVE_TAIL));
            if ($urandom_range(9) == 0)
                p = POS_W'($urandom_range(255));
            else
                p = POS_W'($urandom_range(CAPACITY + 2));
            send_word(m, DATA_W'($urandom_range(255)), p);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = '0;
        value     = '0;
        position  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_list();
        test_output_hold();
        test_random_traffic(160, 0, 0);
        test_random_traffic(160, 88, 0);
        test_random_traffic(160, 0, 88);
        test_random_traffic(160, 11, 11);
        in_valid <= 1'b0;
        while (results_seen < words_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d result words never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/pbl_pkg.sv
design/pbl_cell.sv
design/positional_byte_list_top.sv
verif/positional_byte_list_top_tb.sv
